// ===== sv/ufto_pkg.sv =====
`timescale 1ns / 1ps

package ufto_pkg;

  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;
  localparam int RSLOT_W   = 8;
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 16;
  localparam int SLOT_W    = 8;
  localparam int COUNT_W   = 9;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 24;

  localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd90;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 9'd511;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_TICK   = 2'd1,
    OP_REPLY  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ACT_NEW   = 3'd0,
    ACT_FWD   = 3'd1,
    ACT_DROP  = 3'd2,
    ACT_TICK  = 3'd3,
    ACT_REPLY = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted input transaction, clear scan state
    logic step;    // read one table entry and advance the scan pointer
    logic commit;  // apply the update and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan pointer is at the last entry
    logic out_busy;   // the result register holds a result that is not taken
  } status_t;

endpackage

// ===== sv/udp_flow_table_idle_timeout.sv =====
`timescale 1ns / 1ps

// UDP flow table with idle timeout.
// Input stream (in_*): one transaction per request. in_tuser carries the opcode
// (client packet, one-second tick, reply on slot); in_tdata carries the source
// address, source port and reply slot. Output stream (out_*): one result per
// packet, tick or reply; opcode 3 is consumed without a result. out_tuser is the
// action, out_tdata the slot index and the count of entries freed by a tick.
// cfg_* writes the idle timeout in seconds; write it only while the block is idle.
// Packets and ticks walk the whole table through a single memory read port, one
// entry per cycle, then compare the last entry read, commit and load the result
// register; no new input is taken until they commit. A reply touches one entry
// and goes from acceptance straight to commit.
// A new transaction is taken while the previous result still waits in the output
// register; if the receiver stalls, the finished item holds in the controller
// until the output register frees, and no further input is taken meanwhile.
// Reset frees every entry, clears the seconds counter and sets the timeout to 90;
// no clearing pass is needed.
module udp_flow_table_idle_timeout #(
  parameter int FLOW_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] source_address, [47:32] source_port, [55:48] reply_slot
  input  logic [55:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] slot_index, [16:8] expired_count, [23:17] zero
  output logic [23:0] out_tdata,
  // [2:0] action
  output logic [2:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import ufto_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // The timeout register takes every write at once.
  assign cfg_ready = 1'b1;

  ufto_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ufto_dp #(
    .FLOW_SLOTS (FLOW_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_data    (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/ufto_ctrl.sv =====
`timescale 1ns / 1ps

module ufto_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [1:0]       in_op,
  output logic             in_tready,
  input  ufto_pkg::status_t sts,
  output ufto_pkg::cmd_t    cmd
);
  import ufto_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          unique case (in_op)
            OP_PACKET, OP_TICK: state_nxt = ST_SCAN;
            OP_REPLY:           state_nxt = ST_FINISH;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last entry read is compared in this cycle.
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/ufto_dp.sv =====
`timescale 1ns / 1ps

module ufto_dp #(
  parameter int FLOW_SLOTS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ufto_pkg::cmd_t                    cmd,
  output ufto_pkg::status_t                 sts,
  input  logic [1:0]                        in_op,
  input  logic [ufto_pkg::IN_DATA_W-1:0]    in_data,
  input  logic                              cfg_valid,
  input  logic [ufto_pkg::TMO_W-1:0]        cfg_data,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [ufto_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [2:0]                        out_tuser
);
  import ufto_pkg::*;

  localparam int SW    = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int KEY_W = ADDR_W + PORT_W;

  // Table storage; every entry is read during a scan, but only active entries are used.
  logic [KEY_W-1:0]  key_mem [FLOW_SLOTS];
  logic [TIME_W-1:0] ls_mem  [FLOW_SLOTS];
  logic [FLOW_SLOTS-1:0] active_r;

  logic [TMO_W-1:0]  timeout_r;
  logic [TIME_W-1:0] cur_r;

  opcode_t           op_r;
  logic [KEY_W-1:0]  key_r;
  logic [RSLOT_W-1:0] rslot_r;

  // Scan pointer and the registered read pipeline behind it.
  logic [SW-1:0]     idx_r;
  logic [SW-1:0]     idx_d_r;
  logic              pv_r;
  logic [KEY_W-1:0]  key_q_r;
  logic [TIME_W-1:0] ls_q_r;

  logic              hit_vld_r;
  logic [SW-1:0]     hit_idx_r;
  logic              free_vld_r;
  logic [SW-1:0]     free_idx_r;
  logic [COUNT_W-1:0] cnt_r;

  logic              out_valid_r;
  action_t           res_act_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [COUNT_W-1:0] res_cnt_r;

  logic              ent_active;
  logic [TIME_W-1:0] idle_time;
  logic              expire;
  logic              pkt_hit;
  logic              pkt_free;
  logic [SW+7:0]     rs_ext;
  logic [SW-1:0]     rs_idx;
  logic              rs_in_range;
  logic [SW-1:0]     slot_idx;
  logic [SW+7:0]     slot_ext;
  logic              alloc;
  logic              ls_we;
  logic [SW-1:0]     ls_wa;
  action_t           res_act;
  logic [SLOT_W-1:0] res_slot;
  logic [COUNT_W-1:0] res_cnt;

  assign sts.scan_last = (idx_r == SW'(FLOW_SLOTS - 1));
  assign sts.out_busy  = out_valid_r && !out_tready;

  // Per-entry evaluation of the entry read in the previous cycle.
  assign ent_active = active_r[idx_d_r];
  assign idle_time  = cur_r - ls_q_r;
  assign expire     = pv_r && (op_r == OP_TICK) && ent_active &&
                      (idle_time >= {{(TIME_W-TMO_W){1'b0}}, timeout_r});
  assign pkt_hit    = pv_r && (op_r == OP_PACKET) && ent_active && !hit_vld_r &&
                      (key_q_r == key_r);
  assign pkt_free   = pv_r && (op_r == OP_PACKET) && !ent_active && !free_vld_r;

  assign rs_ext      = {{SW{1'b0}}, rslot_r};
  assign rs_idx      = rs_ext[SW-1:0];
  assign rs_in_range = (rs_ext < (SW+8)'(FLOW_SLOTS));

  assign slot_idx = hit_vld_r ? hit_idx_r : free_idx_r;
  assign slot_ext = {8'd0, slot_idx};

  // Result and table update applied on commit.
  always_comb begin
    alloc    = 1'b0;
    ls_we    = 1'b0;
    ls_wa    = slot_idx;
    res_act  = ACT_DROP;
    res_slot = '0;
    res_cnt  = '0;
    unique case (op_r)
      OP_PACKET: begin
        if (hit_vld_r) begin
          res_act  = ACT_FWD;
          res_slot = slot_ext[SLOT_W-1:0];
          ls_we    = 1'b1;
        end else if (free_vld_r) begin
          res_act  = ACT_NEW;
          res_slot = slot_ext[SLOT_W-1:0];
          ls_we    = 1'b1;
          alloc    = 1'b1;
        end else begin
          res_act  = ACT_DROP;
        end
      end
      OP_TICK: begin
        res_act = ACT_TICK;
        res_cnt = cnt_r;
      end
      OP_REPLY: begin
        res_act  = ACT_REPLY;
        res_slot = rslot_r;
        ls_wa    = rs_idx;
        ls_we    = rs_in_range && active_r[rs_idx];
      end
      default: res_act = ACT_DROP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && alloc) begin
      key_mem[free_idx_r] <= key_r;
    end
    if (cmd.commit && ls_we) begin
      ls_mem[ls_wa] <= cur_r;
    end
    if (cmd.step) begin
      key_q_r <= key_mem[idx_r];
      ls_q_r  <= ls_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      if (expire) begin
        active_r[idx_d_r] <= 1'b0;
      end
      if (cmd.commit && alloc) begin
        active_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      cur_r     <= '0;
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
      if (cmd.load && (in_op == OP_TICK)) begin
        cur_r <= cur_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode_t'(in_op);
      key_r   <= {in_data[ADDR_W+PORT_W-1:ADDR_W], in_data[ADDR_W-1:0]};
      rslot_r <= in_data[IN_DATA_W-1:ADDR_W+PORT_W];
    end
    if (pkt_hit) begin
      hit_idx_r <= idx_d_r;
    end
    if (pkt_free) begin
      free_idx_r <= idx_d_r;
    end
    if (cmd.step) begin
      idx_d_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      pv_r       <= 1'b0;
      hit_vld_r  <= 1'b0;
      free_vld_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      pv_r <= cmd.step;
      if (cmd.load) begin
        idx_r      <= '0;
        hit_vld_r  <= 1'b0;
        free_vld_r <= 1'b0;
        cnt_r      <= '0;
      end else begin
        if (cmd.step && !sts.scan_last) begin
          idx_r <= idx_r + 1'b1;
        end
        if (pkt_hit) begin
          hit_vld_r <= 1'b1;
        end
        if (pkt_free) begin
          free_vld_r <= 1'b1;
        end
        if (expire && (cnt_r != COUNT_MAX)) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_act_r  <= res_act;
      res_slot_r <= res_slot;
      res_cnt_r  <= res_cnt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_act_r;
  assign out_tdata  = {{(OUT_DATA_W-SLOT_W-COUNT_W){1'b0}}, res_cnt_r, res_slot_r};

endmodule

// ===== sim/udp_flow_table_idle_timeout_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the UDP flow table. A scoreboard object mirrors the
// table (live bits, keys, last-seen stamps, seconds counter and idle timeout)
// and works out the result of every accepted request. The DUT results are
// popped in order and compared field by field. Stimulus starts with a short
// directed sequence, then runs random traffic phases at several timeouts:
// key reuse for forwarding hits, a fill phase that overflows the table, a zero
// timeout that flushes a full table, and short timeouts with frequent ticks.
module udp_flow_table_idle_timeout_tb;
  import ufto_pkg::*;

  localparam int FLOW_SLOTS = 256;
  // Packets and ticks scan the whole table; allow a margin on top of that.
  localparam int SCAN_CYCLES = FLOW_SLOTS + 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int KEY_POOL = 16;
  // The opcode that the block consumes without producing a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  slot;
    action_t            action;
  } flow_result_t;

  // Mirror of the flow table plus the queue of results it has predicted.
  class flow_table_scoreboard;
    bit                 flow_live [FLOW_SLOTS];
    logic [ADDR_W-1:0]  flow_addr [FLOW_SLOTS];
    logic [PORT_W-1:0]  flow_port [FLOW_SLOTS];
    logic [TIME_W-1:0]  flow_stamp [FLOW_SLOTS];
    logic [TIME_W-1:0]  now_seconds;
    logic [TMO_W-1:0]   idle_limit;
    flow_result_t       pending_results [$];
    int                 errors;

    function new();
      for (int i = 0; i < FLOW_SLOTS; i++) begin
        flow_live[i] = 1'b0;
        flow_addr[i] = '0;
        flow_port[i] = '0;
        flow_stamp[i] = '0;
      end
      now_seconds = '0;
      idle_limit = TIMEOUT_RESET;
      errors = 0;
    endfunction

    function void set_timeout(logic [TMO_W-1:0] value);
      idle_limit = value;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Update the mirror for one accepted request and queue its result.
    function void apply_request(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                logic [PORT_W-1:0] port, logic [RSLOT_W-1:0] rslot);
      int           hit;
      int           spare;
      int           freed;
      logic [TIME_W-1:0] idle_for;
      flow_result_t r;
      hit = -1;
      spare = -1;
      freed = 0;
      r.count = '0;
      r.slot = '0;
      r.action = ACT_REPLY;
      case (op)
        OP_PACKET: begin
          for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (flow_live[i]) begin
              if (hit < 0 && flow_addr[i] == addr && flow_port[i] == port) hit = i;
            end else if (spare < 0) begin
              spare = i;
            end
          end
          if (hit >= 0) begin
            flow_stamp[hit] = now_seconds;
            r.action = ACT_FWD;
            r.slot = hit[SLOT_W-1:0];
          end else if (spare >= 0) begin
            flow_live[spare] = 1'b1;
            flow_addr[spare] = addr;
            flow_port[spare] = port;
            flow_stamp[spare] = now_seconds;
            r.action = ACT_NEW;
            r.slot = spare[SLOT_W-1:0];
          end else begin
            r.action = ACT_DROP;
          end
          pending_results.push_back(r);
        end
        OP_TICK: begin
          now_seconds = now_seconds + 1'b1;
          for (int i = 0; i < FLOW_SLOTS; i++) begin
            idle_for = now_seconds - flow_stamp[i];
            if (flow_live[i] && idle_for >= {{(TIME_W-TMO_W){1'b0}}, idle_limit}) begin
              flow_live[i] = 1'b0;
              freed++;
            end
          end
          r.action = ACT_TICK;
          r.count = (freed > COUNT_MAX) ? COUNT_MAX : freed[COUNT_W-1:0];
          pending_results.push_back(r);
        end
        OP_REPLY: begin
          if (rslot < FLOW_SLOTS && flow_live[rslot]) flow_stamp[rslot] = now_seconds;
          r.action = ACT_REPLY;
          r.slot = rslot;
          pending_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] act, logic [OUT_DATA_W-1:0] data);
      flow_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: action %0d, data 0x%0h", act, data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (act !== want.action) begin
        $error("action: expected %0d, actual %0d", want.action, act);
        errors++;
      end
      if (data[SLOT_W-1:0] !== want.slot) begin
        $error("slot_index: expected %0d, actual %0d", want.slot, data[SLOT_W-1:0]);
        errors++;
      end
      if (data[SLOT_W+COUNT_W-1:SLOT_W] !== want.count) begin
        $error("expired_count: expected %0d, actual %0d", want.count,
               data[SLOT_W+COUNT_W-1:SLOT_W]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [TMO_W-1:0]      cfg_data;

  flow_table_scoreboard sb;
  int                   cycles = 0;
  int                   requests_sent;
  int                   send_idle_pct;
  int                   take_idle_pct;
  logic [ADDR_W-1:0]    key_addr [KEY_POOL];
  logic [PORT_W-1:0]    key_port [KEY_POOL];

  udp_flow_table_idle_timeout #(
    .FLOW_SLOTS(FLOW_SLOTS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // The receiver decides at each falling edge whether it takes a result at the
  // next rising edge. The stall rate follows the current traffic stage.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= take_idle_pct);
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // Watchdog: a run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and hand it to the
  // scoreboard once the block accepts it. Called and returning at a falling edge.
  // The first third of the traffic stalls the sender lightly and the receiver
  // heavily, the second third the other way round, and the rest runs flat out.
  task automatic send_item(logic [1:0] op, logic [ADDR_W-1:0] addr,
                           logic [PORT_W-1:0] port, logic [RSLOT_W-1:0] rslot);
    if (requests_sent < 450) begin
      send_idle_pct = 29;
      take_idle_pct = 49;
    end else if (requests_sent < 900) begin
      send_idle_pct = 49;
      take_idle_pct = 29;
    end else begin
      send_idle_pct = 0;
      take_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {rslot, port, addr};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    sb.apply_request(op, addr, port, rslot);
    requests_sent++;
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // The timeout may only change while the block is idle: every predicted
  // result has come back, and a full scan time passes before the write as a
  // margin.
  task automatic write_idle_timeout(logic [TMO_W-1:0] value);
    drain_results();
    repeat (SCAN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_timeout(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= TMO_W'($urandom);
  endtask

  task automatic refresh_key_pool();
    for (int k = 0; k < KEY_POOL; k++) begin
      key_addr[k] = $urandom;
      key_port[k] = PORT_W'($urandom);
    end
  endtask

  // Random traffic. Packets mostly reuse a small pool of keys so that flows
  // get hit, refreshed and expired; fresh keys fill the table. Replies lean
  // toward the low slots, which the lowest-free allocation keeps busy. The
  // unused opcode is sprinkled in but does not count toward the total.
  task automatic run_traffic(int total, int tick_pct, int reply_pct, int fresh_pct,
                             int pause_after);
    int                 done;
    int                 roll;
    int                 k;
    logic [1:0]         op;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [RSLOT_W-1:0] rslot;
    done = 0;
    refresh_key_pool();
    while (done < total) begin
      addr = $urandom;
      port = PORT_W'($urandom);
      rslot = RSLOT_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_UNUSED;
      end else if (roll < 3 + tick_pct) begin
        op = OP_TICK;
      end else if (roll < 3 + tick_pct + reply_pct) begin
        op = OP_REPLY;
        if ($urandom_range(0, 99) < 65) rslot = RSLOT_W'($urandom_range(0, 23));
      end else begin
        op = OP_PACKET;
        if ($urandom_range(0, 99) >= fresh_pct) begin
          k = $urandom_range(0, KEY_POOL - 1);
          addr = key_addr[k];
          port = key_port[k];
        end
      end
      send_item(op, addr, port, rslot);
      if (op != OP_UNUSED) begin
        done++;
        if (done == pause_after) drain_results();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    requests_sent = 0;
    send_idle_pct = 29;
    take_idle_pct = 49;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme keys, a hit, replies on live and free slots, the
    // unused opcode, and ticks under the reset timeout.
    send_item(OP_PACKET, 32'h0000_0000, 16'h0000, 8'h00);
    send_item(OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_item(OP_PACKET, 32'h0000_0000, 16'h0000, 8'hFF);
    send_item(OP_PACKET, 32'h0000_0000, 16'hFFFF, 8'h00);
    send_item(OP_PACKET, 32'hFFFF_FFFF, 16'h0000, 8'h00);
    send_item(OP_REPLY, 32'hFFFF_FFFF, 16'hFFFF, 8'd0);
    send_item(OP_REPLY, 32'h0000_0000, 16'h0000, 8'd3);
    send_item(OP_REPLY, 32'h0000_0000, 16'h0000, 8'd255);
    send_item(OP_REPLY, 32'h1234_5678, 16'h9ABC, 8'd200);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_item(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_item(OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
    send_item(OP_UNUSED, 32'h0000_0000, 16'h0000, 8'h00);
    send_item(OP_REPLY, 32'h0000_0000, 16'h0000, 8'd1);

    // A timeout of one second: every tick flushes all live entries.
    write_idle_timeout(16'd1);
    send_item(OP_TICK, 32'h0000_0000, 16'h0000, 8'h00);
    send_item(OP_PACKET, 32'h0000_0000, 16'h0000, 8'h00);
    send_item(OP_TICK, 32'h0000_0000, 16'h0000, 8'h00);
    send_item(OP_REPLY, 32'h0000_0000, 16'h0000, 8'd0);
    run_traffic(230, 15, 20, 20, -1);

    // Longest timeout and mostly fresh keys: the table fills up and later
    // packets get dropped, with hits and replies mixed in.
    write_idle_timeout(16'hFFFF);
    run_traffic(450, 3, 12, 80, 200);

    // Zero timeout: the first tick frees the whole full table at once.
    write_idle_timeout(16'd0);
    send_item(OP_TICK, $urandom, PORT_W'($urandom), RSLOT_W'($urandom));
    run_traffic(150, 20, 20, 30, -1);

    // Short timeouts with frequent ticks, so flows age out between refreshes.
    write_idle_timeout(16'd3);
    run_traffic(250, 20, 20, 25, 120);
    write_idle_timeout(TMO_W'($urandom_range(2, 10)));
    run_traffic(250, 20, 20, 25, -1);

    drain_results();
    repeat (SCAN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
